### hw/rtl/mjt_pkg.sv
// shared types, constants and helpers for the minimum-jerk trajectory generator
`default_nettype none
package mjt_pkg;

	localparam int COEF_COUNT = 6;

	typedef logic signed [63:0] coef_t;
	typedef logic signed [80:0] quot_t;

	// configuration register indices
	localparam logic [2:0] REG_START_POS = 3'd0;
	localparam logic [2:0] REG_START_VEL = 3'd1;
	localparam logic [2:0] REG_START_ACC = 3'd2;
	localparam logic [2:0] REG_END_POS   = 3'd3;
	localparam logic [2:0] REG_END_VEL   = 3'd4;
	localparam logic [2:0] REG_END_ACC   = 3'd5;
	localparam logic [2:0] REG_DURATION  = 3'd6;

	localparam logic [23:0] DURATION_RESET = 24'd131072;

	// input opcodes
	localparam logic OP_PLAN = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// product shift amounts
	localparam logic [5:0] SH0  = 6'd0;
	localparam logic [5:0] SH8  = 6'd8;
	localparam logic [5:0] SH24 = 6'd24;
	localparam logic [5:0] SH32 = 6'd32;

	// clamp on the intermediate acceleration quotient
	localparam quot_t QCLAMP = 81'sd1152921504606846976;

	function automatic logic signed [31:0] sat32(input quot_t v);
		logic signed [31:0] r;
		if (v > 81'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -81'sd2147483648)
			r = 32'sh80000000;
		else
			r = $signed(v[31:0]);
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/minimum_jerk_trajectory.sv
// quintic minimum-jerk trajectory generator, one axis, shared multiplier and divider
// program: a plan request runs twelve nine-digit radix-16 multiplies, each with a load and a
//   commit state, and gives no result; an evaluate request runs four 80-bit restoring
//   divisions plus twelve multiplies to its result
// throughput: one request at a time, the next is taken once the sequencer is back at idle,
//   while an earlier result may still wait in the output register
// reset: arst_n clears the sequencer, coefficients, config registers (duration to 2.0 s)
`default_nettype none
module minimum_jerk_trajectory (
	input  wire                clk,
	input  wire                arst_n,
	// configuration writes
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [31:0]        cfg_data,
	// request channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                op,
	input  wire  [23:0]        sample_time,
	// result channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity,
	output logic signed [31:0] acceleration
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	// program steps: plan first, then evaluate
	localparam logic [4:0] PL_C1  = 5'd0;
	localparam logic [4:0] PL_C2A = 5'd1;
	localparam logic [4:0] PL_C2B = 5'd2;
	localparam logic [4:0] PL_C3V = 5'd3;
	localparam logic [4:0] PL_C3A = 5'd4;
	localparam logic [4:0] PL_C3B = 5'd5;
	localparam logic [4:0] PL_C4V = 5'd6;
	localparam logic [4:0] PL_C4A = 5'd7;
	localparam logic [4:0] PL_C4B = 5'd8;
	localparam logic [4:0] PL_C5V = 5'd9;
	localparam logic [4:0] PL_C5A = 5'd10;
	localparam logic [4:0] PL_C5B = 5'd11;
	localparam logic [4:0] EV_S   = 5'd12;
	localparam logic [4:0] EV_P4  = 5'd13;
	localparam logic [4:0] EV_P3  = 5'd14;
	localparam logic [4:0] EV_P2  = 5'd15;
	localparam logic [4:0] EV_P1  = 5'd16;
	localparam logic [4:0] EV_P0  = 5'd17;
	localparam logic [4:0] EV_V4  = 5'd18;
	localparam logic [4:0] EV_V3  = 5'd19;
	localparam logic [4:0] EV_V2  = 5'd20;
	localparam logic [4:0] EV_V1  = 5'd21;
	localparam logic [4:0] EV_VD  = 5'd22;
	localparam logic [4:0] EV_A4  = 5'd23;
	localparam logic [4:0] EV_A3  = 5'd24;
	localparam logic [4:0] EV_A2  = 5'd25;
	localparam logic [4:0] EV_AD1 = 5'd26;
	localparam logic [4:0] EV_AD2 = 5'd27;

	localparam logic [6:0] MUL_LAST = 7'd8;   // nine radix-16 digits of a 36-bit multiplier
	localparam logic [6:0] DIV_LAST = 7'd79;  // one quotient bit per cycle over 80 bits

	// configuration registers
	logic signed [31:0] start_pos_q, start_vel_q, start_acc_q;
	logic signed [31:0] end_pos_q, end_vel_q, end_acc_q;
	logic [23:0]        duration_q;

	// sequencer
	logic [2:0] st_q;
	logic [4:0] stp_q;
	logic [6:0] cnt_q;

	// coefficient store, normalised time, Q40.24
	mjt_pkg::coef_t coef_q [mjt_pkg::COEF_COUNT];

	// working registers
	logic [23:0]        smp_q;      // latched sample time
	logic [32:0]        s_q;        // normalised time, Q1.32
	mjt_pkg::coef_t     h_q;        // horner accumulator, also plan partial sum
	mjt_pkg::coef_t     tmp_q;      // a * u for the acceleration terms
	logic signed [31:0] pos_res_q, vel_res_q, acc_res_q;

	// shared multiplier
	mjt_pkg::coef_t      mul_a_q;
	logic [35:0]         mul_b_q;
	logic [5:0]          mul_sh_q;
	logic signed [99:0]  mul_acc_q;

	// shared divider
	logic [79:0] div_n_q;          // dividend magnitude in, quotient magnitude out
	logic [23:0] rem_q;
	logic        div_neg_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] position_q, velocity_q, acceleration_q;

	// effective duration: zero acts as one lsb
	logic [23:0] u;
	logic [23:0] tc;
	assign u  = (duration_q == 24'd0) ? 24'd1 : duration_q;
	assign tc = (smp_q > u) ? u : smp_q;

	// sign-extended operands
	mjt_pkg::coef_t x0e, v0e, v1e, a0e, a1e, dxe, vsum;
	assign x0e  = 64'(start_pos_q);
	assign v0e  = 64'(start_vel_q);
	assign v1e  = 64'(end_vel_q);
	assign a0e  = 64'(start_acc_q);
	assign a1e  = 64'(end_acc_q);
	assign dxe  = 64'(end_pos_q) - 64'(start_pos_q);
	assign vsum = v0e + v1e;

	// one multiplier digit a cycle
	logic signed [68:0] pp;
	logic signed [99:0] pp_sh;
	assign pp    = 69'(mul_a_q) * $signed({65'd0, mul_b_q[3:0]});
	assign pp_sh = 100'(pp) <<< {cnt_q[3:0], 2'b00};

	logic signed [99:0] mul_shr;
	mjt_pkg::coef_t     res;
	assign mul_shr = mul_acc_q >>> mul_sh_q;
	assign res     = $signed(mul_shr[63:0]);

	// one restoring divider step
	logic [25:0] trial;
	assign trial = {1'b0, rem_q, div_n_q[79]} - {2'b00, u};

	// floored signed quotient
	mjt_pkg::quot_t qs;
	logic           rem_nz;
	assign rem_nz = (rem_q != 24'd0);
	assign qs = div_neg_q ? (-$signed({1'b0, div_n_q}) - $signed({80'd0, rem_nz}))
	                      : $signed({1'b0, div_n_q});

	// clamp of the first acceleration quotient
	mjt_pkg::coef_t qclamp;
	always_comb begin
		if (qs > mjt_pkg::QCLAMP)
			qclamp = mjt_pkg::QCLAMP[63:0];
		else if (qs < -mjt_pkg::QCLAMP)
			qclamp = $signed(-mjt_pkg::QCLAMP[63:0]);
		else
			qclamp = $signed(qs[63:0]);
	end

	// magnitude of the horner accumulator for the divider
	logic [63:0] hmag;
	assign hmag = h_q[63] ? (~h_q + 64'd1) : h_q;

	// horner addend per step
	mjt_pkg::coef_t c_add;
	always_comb begin
		case (stp_q)
			EV_P4:   c_add = coef_q[4];
			EV_P3:   c_add = coef_q[3];
			EV_P2:   c_add = coef_q[2];
			EV_P1:   c_add = coef_q[1];
			EV_P0:   c_add = coef_q[0];
			EV_V4:   c_add = coef_q[4] <<< 2;
			EV_V3:   c_add = (coef_q[3] <<< 1) + coef_q[3];
			EV_V2:   c_add = coef_q[2] <<< 1;
			EV_V1:   c_add = coef_q[1];
			EV_A4:   c_add = (coef_q[4] <<< 3) + (coef_q[4] <<< 2);
			EV_A3:   c_add = (coef_q[3] <<< 2) + (coef_q[3] <<< 1);
			EV_A2:   c_add = coef_q[2] <<< 1;
			default: c_add = 64'sd0;
		endcase
	end

	mjt_pkg::coef_t nh;
	assign nh = res + c_add;

	// multiplicand per plan step
	mjt_pkg::coef_t pl_a;
	always_comb begin
		case (stp_q)
			PL_C1:   pl_a = v0e;
			PL_C2A:  pl_a = a0e;
			PL_C3V:  pl_a = (v1e <<< 3) + (v0e <<< 3) + (v0e <<< 2);
			PL_C3A:  pl_a = (a0e <<< 1) + a0e - a1e;
			PL_C4V:  pl_a = (v1e <<< 4) - (v1e <<< 1) + (v0e <<< 4);
			PL_C4A:  pl_a = (a0e <<< 1) + a0e - (a1e <<< 1);
			PL_C5V:  pl_a = (vsum <<< 2) + (vsum <<< 1);
			PL_C5A:  pl_a = a0e - a1e;
			default: pl_a = tmp_q;  // second pass of an acceleration term
		endcase
	end

	logic pl_sh24, pl_sh8;
	assign pl_sh24 = (stp_q == PL_C2B) || (stp_q == PL_C3B) || (stp_q == PL_C4B) ||
	                 (stp_q == PL_C5B);
	assign pl_sh8  = (stp_q == PL_C1) || (stp_q == PL_C3V) || (stp_q == PL_C4V) ||
	                 (stp_q == PL_C5V);

	logic is_div;
	assign is_div = (stp_q == EV_S) || (stp_q == EV_VD) || (stp_q == EV_AD1) ||
	                (stp_q == EV_AD2);

	assign cfg_ready    = 1'b1;
	assign in_stall     = (st_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign velocity     = velocity_q;
	assign acceleration = acceleration_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q <= '0;
			start_vel_q <= '0;
			start_acc_q <= '0;
			end_pos_q   <= '0;
			end_vel_q   <= '0;
			end_acc_q   <= '0;
			duration_q  <= mjt_pkg::DURATION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mjt_pkg::REG_START_POS: start_pos_q <= $signed(cfg_data);
				mjt_pkg::REG_START_VEL: start_vel_q <= $signed(cfg_data);
				mjt_pkg::REG_START_ACC: start_acc_q <= $signed(cfg_data);
				mjt_pkg::REG_END_POS:   end_pos_q   <= $signed(cfg_data);
				mjt_pkg::REG_END_VEL:   end_vel_q   <= $signed(cfg_data);
				mjt_pkg::REG_END_ACC:   end_acc_q   <= $signed(cfg_data);
				mjt_pkg::REG_DURATION:  duration_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// sequencer, coefficient store and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			stp_q       <= PL_C1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < mjt_pkg::COEF_COUNT; i++)
				coef_q[i] <= '0;
		end else begin
			// the final state reloads the output register itself
			if (out_valid_q && !out_stall && st_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						smp_q <= sample_time;
						st_q  <= ST_LOAD;
						if (op == mjt_pkg::OP_PLAN) begin
							coef_q[0] <= x0e <<< 8;
							stp_q     <= PL_C1;
						end else begin
							stp_q <= EV_S;
						end
					end
				end
				ST_LOAD: begin
					cnt_q     <= '0;
					mul_acc_q <= '0;
					rem_q     <= '0;
					if (is_div) begin
						st_q <= ST_DIV;
						case (stp_q)
							EV_S: begin
								div_n_q   <= {24'd0, tc, 32'd0};
								div_neg_q <= 1'b0;
							end
							EV_AD1: begin
								div_n_q   <= {hmag, 16'd0};
								div_neg_q <= h_q[63];
							end
							default: begin
								div_n_q   <= {8'd0, hmag, 8'd0};
								div_neg_q <= h_q[63];
							end
						endcase
					end else begin
						st_q <= ST_MUL;
						if (stp_q >= EV_S) begin
							mul_a_q  <= h_q;
							mul_b_q  <= {3'd0, s_q};
							mul_sh_q <= mjt_pkg::SH32;
						end else begin
							mul_a_q  <= pl_a;
							mul_b_q  <= {12'd0, u};
							mul_sh_q <= pl_sh24 ? mjt_pkg::SH24
							          : (pl_sh8 ? mjt_pkg::SH8 : mjt_pkg::SH0);
						end
					end
				end
				ST_MUL: begin
					mul_acc_q <= mul_acc_q + pp_sh;
					mul_b_q   <= mul_b_q >> 4;
					if (cnt_q == MUL_LAST)
						st_q <= ST_COMMIT;
					else
						cnt_q <= cnt_q + 7'd1;
				end
				ST_DIV: begin
					if (!trial[25])
						rem_q <= trial[23:0];
					else
						rem_q <= {rem_q[22:0], div_n_q[79]};
					div_n_q <= {div_n_q[78:0], ~trial[25]};
					if (cnt_q == DIV_LAST)
						st_q <= ST_COMMIT;
					else
						cnt_q <= cnt_q + 7'd1;
				end
				ST_COMMIT: begin
					st_q  <= ST_LOAD;
					stp_q <= stp_q + 5'd1;
					case (stp_q)
						PL_C1:  coef_q[1] <= res;
						PL_C2B: coef_q[2] <= res >>> 1;
						PL_C3V: h_q <= (dxe <<< 12) + (dxe <<< 10) - res;
						PL_C3B: coef_q[3] <= (h_q - res) >>> 1;
						PL_C4V: h_q <= (dxe <<< 9) - (dxe <<< 13) + res;
						PL_C4B: coef_q[4] <= (h_q + res) >>> 1;
						PL_C5V: h_q <= (dxe <<< 11) + (dxe <<< 10) - res;
						PL_C5B: begin
							coef_q[5] <= (h_q - res) >>> 1;
							st_q      <= ST_IDLE;
						end
						PL_C2A, PL_C3A, PL_C4A, PL_C5A: tmp_q <= res;
						EV_S: begin
							s_q <= div_n_q[32:0];
							h_q <= coef_q[5];
						end
						EV_P0: begin
							pos_res_q <= mjt_pkg::sat32(81'(nh >>> 8));
							h_q       <= (coef_q[5] <<< 2) + coef_q[5];
						end
						EV_VD: begin
							vel_res_q <= mjt_pkg::sat32(qs);
							h_q       <= (coef_q[5] <<< 4) + (coef_q[5] <<< 2);
						end
						EV_AD1: h_q <= qclamp;
						EV_AD2: begin
							acc_res_q <= mjt_pkg::sat32(qs);
							st_q      <= ST_FIN;
						end
						default: h_q <= nh;  // remaining horner steps
					endcase
				end
				ST_FIN: begin
					// wait for the output register to free up
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						position_q     <= pos_res_q;
						velocity_q     <= vel_res_q;
						acceleration_q <= acc_res_q;
						st_q           <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a fresh result only ever comes out of the final state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == ST_FIN)
		else $error("result raised outside final state");

	// multiplier digit count stays within the nine digits
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL) |-> (cnt_q <= MUL_LAST))
		else $error("multiplier ran past its last digit");

	// the divider only ever runs on a division step
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> is_div)
		else $error("divider running on a multiply step");

	// an accepted plan request starts at the first plan step
	a_plan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == mjt_pkg::OP_PLAN) |=>
			(st_q == ST_LOAD && stp_q == PL_C1))
		else $error("plan request did not start the plan program");
`endif

endmodule
`default_nettype wire
